@@ rtl/core/trc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the textured rectangle clipper.
// Used by trc_front, trc_fifo, trc_back, the top level and its checker.
package trc_pkg;

  localparam int NUM_LANES  = 4;   // x lo, y lo, x hi, y hi
  localparam int DIV_STEPS  = 16;  // one quotient bit per divider stage
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int LANE_X_LO = 0;
  localparam int LANE_Y_LO = 1;
  localparam int LANE_X_HI = 2;
  localparam int LANE_Y_HI = 3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_WIN_LEFT   = 3'd0,
    REG_WIN_TOP    = 3'd1,
    REG_WIN_RIGHT  = 3'd2,
    REG_WIN_BOTTOM = 3'd3,
    REG_POS_X      = 3'd4,
    REG_POS_Y      = 3'd5,
    REG_CLEAR_MODE = 3'd6,
    REG_DEPTH_Z    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [11:0] win_left;
    logic signed [11:0] win_top;
    logic signed [11:0] win_right;
    logic signed [11:0] win_bottom;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic               clear_mode;
    logic [23:0]        depth_z;
  } cfg_t;

  // per-axis remap operands, all magnitudes
  typedef struct packed {
    logic [15:0] src;    // source extent, hi - lo
    logic [15:0] d_lo;   // how far the low corner moved inward
    logic [15:0] d_hi;   // how far the high corner moved inward
    logic [15:0] t_lo;
    logic [15:0] t_hi;
    logic [15:0] t_mag;  // |t_hi - t_lo|
    logic        t_neg;  // texture extent is negative
  } axis_t;

  // one kept rectangle between front and back
  typedef struct packed {
    logic signed [15:0] q_left;
    logic signed [15:0] q_top;
    logic signed [15:0] q_right;
    logic signed [15:0] q_bottom;
    axis_t              ax_x;
    axis_t              ax_y;
    logic [31:0]        color;
  } item_t;

  // restoring divider lane state
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] low;
    logic [15:0] quot;
  } lane_t;

  typedef struct packed {
    logic signed [15:0] q_left;
    logic signed [15:0] q_top;
    logic signed [15:0] q_right;
    logic signed [15:0] q_bottom;
    logic [15:0]        uv_left;
    logic [15:0]        uv_top;
    logic [15:0]        uv_right;
    logic [15:0]        uv_bottom;
    logic [31:0]        color;
  } result_t;

  // one restoring division step; the remainder stays below the divisor when it starts below it
  function automatic lane_t div_step(lane_t l, logic [15:0] d);
    logic [16:0] trial;
    lane_t       r;
    trial  = {l.rem, l.low[15]};
    r.low  = {l.low[14:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem  = 16'(trial - {1'b0, d});
      r.quot = {l.quot[14:0], 1'b1};
    end else begin
      r.rem  = trial[15:0];
      r.quot = {l.quot[14:0], 1'b0};
    end
    return r;
  endfunction

  // base plus or minus quotient, saturated to 0..65535
  function automatic logic [15:0] uv_final(logic [15:0] base, logic [15:0] q, logic sub);
    logic signed [17:0] s;
    if (sub) s = $signed({2'b00, base}) - $signed({2'b00, q});
    else     s = $signed({2'b00, base}) + $signed({2'b00, q});
    if (s < 0)             return 16'd0;
    else if (s > 18'sd65535) return 16'hFFFF;
    else                   return s[15:0];
  endfunction

endpackage

@@ rtl/core/trc_fifo.sv @@
// Short queue of kept rectangles between the front and back parts.
// Depends on trc_pkg for item_t and the depth constants.
module trc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  trc_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output trc_pkg::item_t data_o,
  output logic           empty_o
);
  import trc_pkg::*;

  item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o)  wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && !empty_o)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ rtl/core/trc_front.sv @@
// Front part: accepts rectangles, orders and offsets the corners, clips them and
// drops empty results. Kept items go to the queue. Depends on trc_pkg.
module trc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trc_pkg::cfg_t      cfg_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] size_x_i,
  input  logic signed [15:0] size_y_i,
  input  logic [15:0]        tex_left_i,
  input  logic [15:0]        tex_top_i,
  input  logic [15:0]        tex_right_i,
  input  logic [15:0]        tex_bottom_i,
  input  logic [31:0]        rect_color_i,
  input  logic               fifo_full_i,
  output logic               fifo_push_o,
  output trc_pkg::item_t     item_o
);
  import trc_pkg::*;

  typedef struct packed {
    logic signed [15:0] c_lo;
    logic signed [15:0] c_hi;
    logic               keep;
    axis_t              ax;
  } axis_res_t;

  // clip one axis and gather its remap operands
  function automatic axis_res_t do_axis(logic signed [15:0] p, logic signed [15:0] sz,
                                        logic signed [11:0] pos, logic signed [11:0] wlo,
                                        logic signed [11:0] whi, logic [15:0] tlo,
                                        logic [15:0] thi);
    logic signed [16:0] pe, e, lo, hi, ext;
    logic signed [17:0] off, s_lo, s_hi, w_lo, w_hi, m_lo, m_hi, c_lo, c_hi;
    logic signed [17:0] dl, dh;
    logic signed [16:0] tx;
    axis_res_t r;
    pe   = 17'(p);
    e    = pe + 17'(sz);
    lo   = (e < pe) ? e : pe;
    hi   = (e < pe) ? pe : e;
    ext  = hi - lo;
    off  = 18'($signed({pos, 4'b0000}));
    s_lo = 18'(lo) + off;
    s_hi = 18'(hi) + off;
    w_lo = 18'($signed({wlo, 4'b0000}));
    w_hi = 18'($signed({whi, 4'b0000}));
    m_lo = (s_lo < w_hi) ? s_lo : w_hi;
    m_hi = (s_hi < w_hi) ? s_hi : w_hi;
    c_lo = (m_lo > w_lo) ? m_lo : w_lo;
    c_hi = (m_hi > w_lo) ? m_hi : w_lo;
    dl   = c_lo - s_lo;
    dh   = s_hi - c_hi;
    tx   = $signed({1'b0, thi}) - $signed({1'b0, tlo});
    r.c_lo     = c_lo[15:0];
    r.c_hi     = c_hi[15:0];
    r.keep     = (c_hi > c_lo);
    r.ax.src   = ext[15:0];
    r.ax.d_lo  = dl[15:0];
    r.ax.d_hi  = dh[15:0];
    r.ax.t_lo  = tlo;
    r.ax.t_hi  = thi;
    r.ax.t_neg = tx[16];
    r.ax.t_mag = tx[16] ? 16'(-tx) : tx[15:0];
    return r;
  endfunction

  axis_res_t rx, ry;
  item_t     item_d, item_q;
  logic      keep_d, keep_q, valid_q, take;

  // classification
  always_comb begin
    rx = do_axis(rect_x_i, size_x_i, cfg_i.pos_x, cfg_i.win_left, cfg_i.win_right,
                 tex_left_i, tex_right_i);
    ry = do_axis(rect_y_i, size_y_i, cfg_i.pos_y, cfg_i.win_top, cfg_i.win_bottom,
                 tex_top_i, tex_bottom_i);
    keep_d          = rx.keep && ry.keep;
    item_d.q_left   = rx.c_lo;
    item_d.q_right  = rx.c_hi;
    item_d.q_top    = ry.c_lo;
    item_d.q_bottom = ry.c_hi;
    item_d.ax_x     = rx.ax;
    item_d.ax_y     = ry.ax;
    item_d.color    = rect_color_i;
  end

  // holding register: only a kept item waits on the queue
  assign full        = valid_q && keep_q && fifo_full_i;
  assign take        = push && !full;
  assign fifo_push_o = valid_q && keep_q && !fifo_full_i;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      keep_q  <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
      keep_q  <= keep_d;
    end else if (!full) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
  end

endmodule

@@ rtl/core/trc_back.sv @@
// Back part: texture remap. Four multipliers, a 16-stage restoring divider per lane,
// then the offset add, saturation and the output register. Depends on trc_pkg.
module trc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_mode_i,
  input  logic               fifo_empty_i,
  input  trc_pkg::item_t     item_i,
  output logic               fifo_pop_o,
  input  logic               pop,
  output logic               empty,
  output trc_pkg::result_t   res_o
);
  import trc_pkg::*;

  typedef struct packed {
    item_t                     item;
    lane_t [NUM_LANES-1:0]     lane;
  } stage_t;

  logic     advance;
  logic     s0_valid_q, out_valid_q;
  logic     stg_valid_q [DIV_STEPS+1];
  item_t    s0_q;
  stage_t   stg_q [DIV_STEPS+1];
  result_t  res_q, res_d;
  logic [31:0] prod [NUM_LANES];

  // the whole pipe moves when the output register is free or being emptied
  assign advance    = !out_valid_q || pop;
  assign fifo_pop_o = advance && !fifo_empty_i;
  assign empty      = !out_valid_q;
  assign res_o      = res_q;

  // products of inward move and texture extent
  always_comb begin
    prod[LANE_X_LO] = s0_q.ax_x.d_lo * s0_q.ax_x.t_mag;
    prod[LANE_Y_LO] = s0_q.ax_y.d_lo * s0_q.ax_y.t_mag;
    prod[LANE_X_HI] = s0_q.ax_x.d_hi * s0_q.ax_x.t_mag;
    prod[LANE_Y_HI] = s0_q.ax_y.d_hi * s0_q.ax_y.t_mag;
  end

  // final add or subtract and saturate; clear mode zeroes the colour
  always_comb begin
    item_t it;
    it = stg_q[DIV_STEPS].item;
    res_d.q_left    = it.q_left;
    res_d.q_top     = it.q_top;
    res_d.q_right   = it.q_right;
    res_d.q_bottom  = it.q_bottom;
    res_d.uv_left   = uv_final(it.ax_x.t_lo, stg_q[DIV_STEPS].lane[LANE_X_LO].quot,
                               it.ax_x.t_neg);
    res_d.uv_top    = uv_final(it.ax_y.t_lo, stg_q[DIV_STEPS].lane[LANE_Y_LO].quot,
                               it.ax_y.t_neg);
    res_d.uv_right  = uv_final(it.ax_x.t_hi, stg_q[DIV_STEPS].lane[LANE_X_HI].quot,
                               !it.ax_x.t_neg);
    res_d.uv_bottom = uv_final(it.ax_y.t_hi, stg_q[DIV_STEPS].lane[LANE_Y_HI].quot,
                               !it.ax_y.t_neg);
    res_d.color     = clear_mode_i ? 32'd0 : it.color;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) stg_valid_q[i] <= 1'b0;
    end else if (advance) begin
      s0_valid_q     <= !fifo_empty_i;
      stg_valid_q[0] <= s0_valid_q;
      for (int i = 0; i < DIV_STEPS; i++) stg_valid_q[i+1] <= stg_valid_q[i];
      out_valid_q    <= stg_valid_q[DIV_STEPS];
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s0_q <= item_i;
      stg_q[0].item <= s0_q;
      for (int l = 0; l < NUM_LANES; l++) begin
        stg_q[0].lane[l].rem  <= prod[l][31:16];
        stg_q[0].lane[l].low  <= prod[l][15:0];
        stg_q[0].lane[l].quot <= '0;
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        stg_q[i+1].item <= stg_q[i].item;
        stg_q[i+1].lane[LANE_X_LO] <= div_step(stg_q[i].lane[LANE_X_LO],
                                               stg_q[i].item.ax_x.src);
        stg_q[i+1].lane[LANE_X_HI] <= div_step(stg_q[i].lane[LANE_X_HI],
                                               stg_q[i].item.ax_x.src);
        stg_q[i+1].lane[LANE_Y_LO] <= div_step(stg_q[i].lane[LANE_Y_LO],
                                               stg_q[i].item.ax_y.src);
        stg_q[i+1].lane[LANE_Y_HI] <= div_step(stg_q[i].lane[LANE_Y_HI],
                                               stg_q[i].item.ax_y.src);
      end
      res_q <= res_d;
    end
  end

endmodule

@@ rtl/core/textured_rect_clipper.sv @@
// Textured rectangle clipper top level: configuration registers, front, queue, back.
// Depends on trc_pkg, trc_front, trc_fifo and trc_back.
//
// One rectangle is accepted per clock and one result delivered per clock when both
// sides keep moving. A kept rectangle goes through the front register, loaded at the
// accepting edge, then the queue, the operand register and the multiply stage, 16
// divider stages (one quotient bit per stage) and the output register. A waiting
// result stalls the whole back part. Dropped rectangles produce nothing. The
// configuration port is always ready; write it only while the block is idle.
module textured_rect_clipper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_addr_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] size_x_i,
  input  logic signed [15:0] size_y_i,
  input  logic [15:0]        tex_left_i,
  input  logic [15:0]        tex_top_i,
  input  logic [15:0]        tex_right_i,
  input  logic [15:0]        tex_bottom_i,
  input  logic [31:0]        rect_color_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] quad_left_o,
  output logic signed [15:0] quad_top_o,
  output logic signed [15:0] quad_right_o,
  output logic signed [15:0] quad_bottom_o,
  output logic [15:0]        uv_left_o,
  output logic [15:0]        uv_top_o,
  output logic [15:0]        uv_right_o,
  output logic [15:0]        uv_bottom_o,
  output logic [31:0]        out_color_o,
  output logic [23:0]        out_depth_o
);
  import trc_pkg::*;

  cfg_t    cfg_q;
  item_t   fr_item, q_item;
  logic    fifo_push, fifo_full, fifo_pop, fifo_empty;
  result_t res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_left   <= 12'sd0;
      cfg_q.win_top    <= 12'sd0;
      cfg_q.win_right  <= 12'sd2047;
      cfg_q.win_bottom <= 12'sd2047;
      cfg_q.pos_x      <= 12'sd0;
      cfg_q.pos_y      <= 12'sd0;
      cfg_q.clear_mode <= 1'b0;
      cfg_q.depth_z    <= 24'd0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_WIN_LEFT:   cfg_q.win_left   <= cfg_data_i[11:0];
        REG_WIN_TOP:    cfg_q.win_top    <= cfg_data_i[11:0];
        REG_WIN_RIGHT:  cfg_q.win_right  <= cfg_data_i[11:0];
        REG_WIN_BOTTOM: cfg_q.win_bottom <= cfg_data_i[11:0];
        REG_POS_X:      cfg_q.pos_x      <= cfg_data_i[11:0];
        REG_POS_Y:      cfg_q.pos_y      <= cfg_data_i[11:0];
        REG_CLEAR_MODE: cfg_q.clear_mode <= cfg_data_i[0];
        REG_DEPTH_Z:    cfg_q.depth_z    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  trc_front u_front (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .push,
    .full,
    .rect_x_i, .rect_y_i, .size_x_i, .size_y_i,
    .tex_left_i, .tex_top_i, .tex_right_i, .tex_bottom_i,
    .rect_color_i,
    .fifo_full_i  (fifo_full),
    .fifo_push_o  (fifo_push),
    .item_o       (fr_item)
  );

  trc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (fifo_push),
    .data_i  (fr_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (q_item),
    .empty_o (fifo_empty)
  );

  trc_back u_back (
    .clk_i, .rst_ni,
    .clear_mode_i (cfg_q.clear_mode),
    .fifo_empty_i (fifo_empty),
    .item_i       (q_item),
    .fifo_pop_o   (fifo_pop),
    .pop,
    .empty,
    .res_o        (res)
  );

  // result ports
  assign quad_left_o   = res.q_left;
  assign quad_top_o    = res.q_top;
  assign quad_right_o  = res.q_right;
  assign quad_bottom_o = res.q_bottom;
  assign uv_left_o     = res.uv_left;
  assign uv_top_o      = res.uv_top;
  assign uv_right_o    = res.uv_right;
  assign uv_bottom_o   = res.uv_bottom;
  assign out_color_o   = res.color;
  assign out_depth_o   = cfg_q.depth_z;

endmodule

@@ rtl/core/trc_checker.sv @@
// Port-level checks for the textured rectangle clipper, bound to the top level.
// Depends only on the top level's port names.
module trc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] quad_left_o,
  input logic signed [15:0] quad_top_o,
  input logic signed [15:0] quad_right_o,
  input logic signed [15:0] quad_bottom_o
);

  // a waiting result stays until taken, checked on its left and right edges
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(quad_left_o) && $stable(quad_right_o))
    else $error("result changed while stalled");

  // emitted quads are never empty horizontally
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> quad_right_o > quad_left_o)
    else $error("emitted quad has no width");

  // emitted quads are never empty vertically
  a_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> quad_bottom_o > quad_top_o)
    else $error("emitted quad has no height");

endmodule

bind textured_rect_clipper trc_checker u_trc_checker (.*);

@@ verif/textured_rect_clipper_checker.sv @@
// Checker for the textured rectangle clipper: it watches the config, rectangle and quad
// channels, predicts each quad and compares the fields. Depends on trc_pkg.
module textured_rect_clipper_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic signed [15:0] size_x_i,
  input  logic signed [15:0] size_y_i,
  input  logic [15:0]        tex_left_i,
  input  logic [15:0]        tex_top_i,
  input  logic [15:0]        tex_right_i,
  input  logic [15:0]        tex_bottom_i,
  input  logic [31:0]        rect_color_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [15:0] quad_left_i,
  input  logic signed [15:0] quad_top_i,
  input  logic signed [15:0] quad_right_i,
  input  logic signed [15:0] quad_bottom_i,
  input  logic [15:0]        uv_left_i,
  input  logic [15:0]        uv_top_i,
  input  logic [15:0]        uv_right_i,
  input  logic [15:0]        uv_bottom_i,
  input  logic [31:0]        out_color_i,
  input  logic [23:0]        out_depth_i,
  output int                 fails_o,
  output int                 pending_o,
  output int                 rects_o,
  output int                 quads_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import trc_pkg::*;

  typedef struct {
    logic signed [15:0] left, top, right, bottom;
    logic [15:0]        u_left, u_top, u_right, u_bottom;
    logic [31:0]        color;
    logic [23:0]        depth;
  } quad_t;

  // shadow of the configuration registers, in whole pixels
  longint win_l, win_t, win_r, win_b, off_x, off_y;
  logic        clr;
  logic [23:0] depth;
  quad_t       quad_q[$];

  function automatic logic [15:0] sat16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // texture edge moved by the share of the source extent that was clipped away
  function automatic logic [15:0] uv_remap(longint base, longint ext, longint delta,
                                           longint src);
    if (src <= 0) return sat16(base);
    return sat16(base + (delta * ext) / src);
  endfunction

  // returns 1 and fills q when the rectangle survives clipping
  function automatic bit clip_rect(output quad_t q);
    longint rx, ry, x1, x2, y1, y2, cx1, cx2, cy1, cy2, wl, wr, wt, wb;
    longint tl, tt, tr, tb;
    rx = longint'(rect_x_i) + longint'(size_x_i);
    ry = longint'(rect_y_i) + longint'(size_y_i);
    x1 = (rx < rect_x_i ? rx : rect_x_i) + off_x * 16;
    x2 = (rx > rect_x_i ? rx : rect_x_i) + off_x * 16;
    y1 = (ry < rect_y_i ? ry : rect_y_i) + off_y * 16;
    y2 = (ry > rect_y_i ? ry : rect_y_i) + off_y * 16;
    wl = win_l * 16; wr = win_r * 16; wt = win_t * 16; wb = win_b * 16;
    cx1 = x1 < wr ? x1 : wr; if (cx1 < wl) cx1 = wl;
    cx2 = x2 < wr ? x2 : wr; if (cx2 < wl) cx2 = wl;
    cy1 = y1 < wb ? y1 : wb; if (cy1 < wt) cy1 = wt;
    cy2 = y2 < wb ? y2 : wb; if (cy2 < wt) cy2 = wt;
    if (cx2 - cx1 <= 0 || cy2 - cy1 <= 0) return 0;
    tl = tex_left_i; tt = tex_top_i; tr = tex_right_i; tb = tex_bottom_i;
    q.left     = cx1[15:0];
    q.top      = cy1[15:0];
    q.right    = cx2[15:0];
    q.bottom   = cy2[15:0];
    q.u_left   = uv_remap(tl, tr - tl, cx1 - x1, x2 - x1);
    q.u_top    = uv_remap(tt, tb - tt, cy1 - y1, y2 - y1);
    q.u_right  = uv_remap(tr, tr - tl, cx2 - x2, x2 - x1);
    q.u_bottom = uv_remap(tb, tb - tt, cy2 - y2, y2 - y1);
    q.color    = clr ? 32'd0 : rect_color_i;
    q.depth    = depth;
    return 1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    quad_t q;
    if (!rst_ni) begin
      win_l <= 0; win_t <= 0; win_r <= 2047; win_b <= 2047;
      off_x <= 0; off_y <= 0; clr <= 1'b0; depth <= '0;
      fails_o <= 0; pending_o <= 0; rects_o <= 0; quads_o <= 0;
    end else begin
      // register write transfer
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_WIN_LEFT:   win_l <= longint'($signed(cfg_data_i[11:0]));
          REG_WIN_TOP:    win_t <= longint'($signed(cfg_data_i[11:0]));
          REG_WIN_RIGHT:  win_r <= longint'($signed(cfg_data_i[11:0]));
          REG_WIN_BOTTOM: win_b <= longint'($signed(cfg_data_i[11:0]));
          REG_POS_X:      off_x <= longint'($signed(cfg_data_i[11:0]));
          REG_POS_Y:      off_y <= longint'($signed(cfg_data_i[11:0]));
          REG_CLEAR_MODE: clr   <= cfg_data_i[0];
          REG_DEPTH_Z:    depth <= cfg_data_i;
          default: ;
        endcase
      end
      // quad transfer: compare with the oldest prediction
      if (pop_i && !empty_i) begin
        quads_o <= quads_o + 1;
        if (quad_q.size() == 0) begin
          $error("quad delivered with none predicted");
          fails_o <= fails_o + 1;
        end else begin
          q = quad_q.pop_front();
          if ({quad_left_i, quad_top_i, quad_right_i, quad_bottom_i, uv_left_i, uv_top_i,
               uv_right_i, uv_bottom_i, out_color_i, out_depth_i} !==
              {q.left, q.top, q.right, q.bottom, q.u_left, q.u_top, q.u_right,
               q.u_bottom, q.color, q.depth}) begin
            fails_o <= fails_o + 1;
            if (quad_left_i !== q.left)
              $error("quad_left exp %0d got %0d", q.left, quad_left_i);
            if (quad_top_i !== q.top)
              $error("quad_top exp %0d got %0d", q.top, quad_top_i);
            if (quad_right_i !== q.right)
              $error("quad_right exp %0d got %0d", q.right, quad_right_i);
            if (quad_bottom_i !== q.bottom)
              $error("quad_bottom exp %0d got %0d", q.bottom, quad_bottom_i);
            if (uv_left_i !== q.u_left)
              $error("uv_left exp %0d got %0d", q.u_left, uv_left_i);
            if (uv_top_i !== q.u_top)
              $error("uv_top exp %0d got %0d", q.u_top, uv_top_i);
            if (uv_right_i !== q.u_right)
              $error("uv_right exp %0d got %0d", q.u_right, uv_right_i);
            if (uv_bottom_i !== q.u_bottom)
              $error("uv_bottom exp %0d got %0d", q.u_bottom, uv_bottom_i);
            if (out_color_i !== q.color)
              $error("out_color exp %h got %h", q.color, out_color_i);
            if (out_depth_i !== q.depth)
              $error("out_depth exp %h got %h", q.depth, out_depth_i);
          end
        end
      end
      // rectangle transfer: predict
      if (push_i && !full_i) begin
        rects_o <= rects_o + 1;
        if (clip_rect(q)) quad_q.push_back(q);
      end
      pending_o <= quad_q.size();
    end
  end

endmodule

@@ verif/textured_rect_clipper_tb.sv @@
// Testbench top for the textured rectangle clipper: clock, reset, rectangle and config
// stimulus, random quad back-pressure and the verdict. Depends on trc_pkg and the checker.
module textured_rect_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_addr = '0;
  logic [23:0] cfg_data = '0;
  logic push = 1'b0, full, empty, pop = 1'b0;
  logic signed [15:0] rect_x = '0, rect_y = '0, size_x = '0, size_y = '0;
  logic [15:0] tex_left = '0, tex_top = '0, tex_right = '0, tex_bottom = '0;
  logic [31:0] rect_color = '0;
  logic signed [15:0] quad_left, quad_top, quad_right, quad_bottom;
  logic [15:0] uv_left, uv_top, uv_right, uv_bottom;
  logic [31:0] out_color;
  logic [23:0] out_depth;
  int fails, pending, rects, quads, cycles;
  bit no_idle = 1'b0;
  // window and offset as last written, used to aim rectangles at the window
  int aim_l = 0, aim_t = 0, aim_r = 2047, aim_b = 2047, aim_x = 0, aim_y = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  textured_rect_clipper i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_addr_i(cfg_addr),
    .cfg_data_i(cfg_data), .push(push), .full(full),
    .rect_x_i(rect_x), .rect_y_i(rect_y), .size_x_i(size_x), .size_y_i(size_y),
    .tex_left_i(tex_left), .tex_top_i(tex_top), .tex_right_i(tex_right),
    .tex_bottom_i(tex_bottom), .rect_color_i(rect_color),
    .empty(empty), .pop(pop),
    .quad_left_o(quad_left), .quad_top_o(quad_top), .quad_right_o(quad_right),
    .quad_bottom_o(quad_bottom), .uv_left_o(uv_left), .uv_top_o(uv_top),
    .uv_right_o(uv_right), .uv_bottom_o(uv_bottom), .out_color_o(out_color),
    .out_depth_o(out_depth)
  );

  textured_rect_clipper_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_addr_i(cfg_addr),
    .cfg_data_i(cfg_data), .push_i(push), .full_i(full),
    .rect_x_i(rect_x), .rect_y_i(rect_y), .size_x_i(size_x), .size_y_i(size_y),
    .tex_left_i(tex_left), .tex_top_i(tex_top), .tex_right_i(tex_right),
    .tex_bottom_i(tex_bottom), .rect_color_i(rect_color),
    .empty_i(empty), .pop_i(pop),
    .quad_left_i(quad_left), .quad_top_i(quad_top), .quad_right_i(quad_right),
    .quad_bottom_i(quad_bottom), .uv_left_i(uv_left), .uv_top_i(uv_top),
    .uv_right_i(uv_right), .uv_bottom_i(uv_bottom), .out_color_i(out_color),
    .out_depth_i(out_depth),
    .fails_o(fails), .pending_o(pending), .rects_o(rects), .quads_o(quads)
  );

  // quad side back-pressure
  always_ff @(posedge clk) begin
    pop <= no_idle || ($urandom_range(99) >= 32);
  end

  // watchdog
  always_ff @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_rect(int rx, int ry, int sx, int sy, logic [15:0] tl,
                           logic [15:0] tt, logic [15:0] tr, logic [15:0] tb,
                           logic [31:0] col);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 32) ? $urandom_range(1, 2) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rect_x <= 16'(rx); rect_y <= 16'(ry); size_x <= 16'(sx); size_y <= 16'(sy);
    tex_left <= tl; tex_top <= tt; tex_right <= tr; tex_bottom <= tb;
    rect_color <= col;
    do @(posedge clk); while (full);
  endtask

  // sender holds off until every predicted quad has been delivered
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    // upper bits are don't-care for the 12-bit registers
    cfg_data  <= (idx == REG_DEPTH_Z) ? 24'(val) : {12'($urandom), 12'(val)};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIN_LEFT:   aim_l = val;
      REG_WIN_TOP:    aim_t = val;
      REG_WIN_RIGHT:  aim_r = val;
      REG_WIN_BOTTOM: aim_b = val;
      REG_POS_X:      aim_x = val;
      REG_POS_Y:      aim_y = val;
      default: ;
    endcase
  endtask

  task automatic set_window(int l, int t, int r, int b, int px, int py, int clr, int dz);
    write_reg(REG_WIN_LEFT, l);
    write_reg(REG_WIN_TOP, t);
    write_reg(REG_WIN_RIGHT, r);
    write_reg(REG_WIN_BOTTOM, b);
    write_reg(REG_POS_X, px);
    write_reg(REG_POS_Y, py);
    write_reg(REG_CLEAR_MODE, clr);
    write_reg(REG_DEPTH_Z, dz);
  endtask

  // coordinate near the window edges once the offset is applied, in Q12.4
  function automatic int aim_coord(int lo, int hi, int off);
    int a, b, v;
    a = (lo < hi ? lo : hi) * 16 - 400;
    b = (lo < hi ? hi : lo) * 16 + 400;
    v = a + int'($urandom_range(b - a)) - off * 16;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task automatic random_rects(int n);
    int sx, sy;
    repeat (n) begin
      if ($urandom_range(99) < 15) begin
        send_rect(int'($urandom_range(65535)), int'($urandom_range(65535)),
                  int'($urandom_range(65535)), int'($urandom_range(65535)),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom);
      end else begin
        sx = ($urandom_range(9) == 0) ? $urandom_range(40000) - 20000
                                      : $urandom_range(2048) - 1024;
        sy = ($urandom_range(9) == 0) ? $urandom_range(40000) - 20000
                                      : $urandom_range(2048) - 1024;
        send_rect(aim_coord(aim_l, aim_r, aim_x), aim_coord(aim_t, aim_b, aim_y), sx, sy,
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window 0..2047 pixels
    send_rect(160, 160, 320, 480, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_rect(-32768, -32768, 32767, 32767, 16'h1000, 16'h2000, 16'h9000, 16'hA000,
              32'h1234_5678);
    send_rect(32767, 32767, -32768, -32768, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
              32'h8000_0001);
    send_rect(-100, 50, 300, 200, 16'h8000, 16'h0100, 16'h4000, 16'hF000, 32'hA5A5_A5A5);
    send_rect(32700, 32700, 500, 500, 16'h0, 16'h7FFF, 16'hFFFF, 16'h8000, 32'h5A5A_5A5A);
    send_rect(300, 300, 0, 100, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 32'h0F0F_0F0F);
    send_rect(300, 300, 100, 0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 32'hF0F0_F0F0);
    send_rect(-500, 100, 500, 100, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 32'h1);
    send_rect(-500, 100, 400, 100, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 32'h2);
    send_rect(32752, 32752, -16, -16, 16'h0, 16'h0, 16'h7FFF, 16'h7FFF, 32'h3);
    send_rect(1000, 1000, -2000, -3000, 16'hC000, 16'h4000, 16'h2000, 16'hE000,
              32'hDEAD_BEEF);
    send_rect(7, 9, 3, 5, 16'h0001, 16'hFFFE, 16'hFFFE, 16'h0001, 32'h0);
    drain();

    // full window, max depth, both offsets at extremes in turn
    set_window(-2048, -2048, 2047, 2047, 0, 0, 0, 24'hFFFFFF);
    send_rect(-32768, -32768, 32767, 32767, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 32'h1);
    send_rect(32767, 32767, -32768, -32768, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 32'h2);
    random_rects(160);
    drain();
    set_window(100, -50, 300, 60, 2047, -2048, 1, 24'h000001);
    random_rects(130);
    drain();
    set_window(-2048, 0, 0, 2047, -2048, 2047, 0, 24'h5A5A5A);
    random_rects(130);
    drain();

    // inverted window drops everything, then a narrow window
    set_window(500, 400, 100, 900, 0, 0, 1, 24'h123456);
    random_rects(20);
    drain();
    set_window(10, 10, 20, 900, 0, 0, 0, 24'h0);
    random_rects(20);
    drain();

    // long stretch, first with no idling on either side, then with idling
    set_window($urandom_range(1000) - 1000, $urandom_range(1000) - 1000,
               $urandom_range(1000) + 1, $urandom_range(1000) + 1,
               $urandom_range(400) - 200, $urandom_range(400) - 200,
               $urandom_range(1), $urandom_range(24'hFFFFFF));
    no_idle = 1'b1;
    random_rects(150);
    no_idle = 1'b0;
    random_rects(150);
    drain();

    $display("Sent %0d rectangles over 7 register settings, %0d quads delivered.",
             rects, quads);
    $display("Settings included inverted, minimal and full windows and offset extremes.");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
